>>> hdl/rhe_pkg.sv
// Shared types and constants for the RGB histogram engine.
package rhe_pkg;

  localparam int OUT_BITS = 24;
  localparam int PIX_BITS = 24;
  localparam int IDX_BITS = 8;
  localparam logic [OUT_BITS-1:0] OUT_MAX = 24'hFFFFFF;

  // Item modes.
  localparam logic MODE_ACCUM = 1'b0;
  localparam logic MODE_READ  = 1'b1;

  // Register map.
  localparam logic REG_CLEAR_ON_READ = 1'b0;

  typedef struct packed {
    logic                mode;
    logic [PIX_BITS-1:0] pixel;
    logic [IDX_BITS-1:0] bin_index;
  } rhe_item_t;

  typedef struct packed {
    logic [OUT_BITS-1:0] count_red;
    logic [OUT_BITS-1:0] count_green;
    logic [OUT_BITS-1:0] count_blue;
    logic [OUT_BITS-1:0] pixel_total;
  } rhe_result_t;

  // Classified command passed from the front end to the update engine.
  // For a read, all three bin fields carry the requested bin.
  typedef struct packed {
    logic                is_read;
    logic                in_range;
    logic [IDX_BITS-1:0] red_bin;
    logic [IDX_BITS-1:0] green_bin;
    logic [IDX_BITS-1:0] blue_bin;
  } rhe_cmd_t;

endpackage

>>> hdl/rhe_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module rhe_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/rhe_front.sv
// Front end: classifies incoming items into bin commands and queues them.
module rhe_front #(
  parameter int BIN_COUNT = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  rhe_pkg::rhe_item_t item,
  output logic              full,
  output logic              cmd_valid,
  output rhe_pkg::rhe_cmd_t cmd,
  input  logic              cmd_pop
);
  import rhe_pkg::*;

  localparam logic [IDX_BITS:0]   BIN_LIMIT = (IDX_BITS + 1)'(BIN_COUNT);
  localparam logic [IDX_BITS-1:0] LAST_BIN  = IDX_BITS'(BIN_COUNT - 1);

  function automatic logic [IDX_BITS-1:0] clamp_bin(input logic [IDX_BITS-1:0] ch);
    return ({1'b0, ch} >= BIN_LIMIT) ? LAST_BIN : ch;
  endfunction

  rhe_cmd_t    new_cmd;
  rhe_cmd_t    entries [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  fill;
  logic        do_push;

  // Channel values beyond the last bin fold into the last bin.
  always_comb begin
    new_cmd.is_read  = (item.mode == MODE_READ);
    new_cmd.in_range = ({1'b0, item.bin_index} < BIN_LIMIT);
    if (item.mode == MODE_READ) begin
      new_cmd.red_bin   = item.bin_index;
      new_cmd.green_bin = item.bin_index;
      new_cmd.blue_bin  = item.bin_index;
    end else begin
      new_cmd.red_bin   = clamp_bin(item.pixel[7:0]);
      new_cmd.green_bin = clamp_bin(item.pixel[15:8]);
      new_cmd.blue_bin  = clamp_bin(item.pixel[23:16]);
    end
  end

  assign full      = (fill == 2'd2);
  assign cmd_valid = (fill != 2'd0);
  assign cmd       = entries[rd_ptr];
  assign do_push   = push && !full;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= new_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (cmd_pop) begin
        rd_ptr <= !rd_ptr;
      end
      fill <= fill + 2'(do_push) - 2'(cmd_pop);
    end
  end

endmodule

>>> hdl/rhe_back.sv
// Update engine: read-modify-write of the three bin memories and result register.
module rhe_back #(
  parameter int BIN_COUNT  = 256,
  parameter int COUNT_BITS = 24
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                clear_on_read,
  input  logic                cmd_valid,
  input  rhe_pkg::rhe_cmd_t   cmd,
  output logic                cmd_pop,
  output logic                empty,
  input  logic                pop,
  output rhe_pkg::rhe_result_t result
);
  import rhe_pkg::*;

  localparam int BIN_BITS = $clog2(BIN_COUNT);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [BIN_BITS-1:0]   LAST_ADDR = BIN_BITS'(BIN_COUNT - 1);

  localparam logic [1:0] S_INIT = 2'd0;
  localparam logic [1:0] S_IDLE = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    return (v == COUNT_MAX) ? v : v + COUNT_BITS'(1);
  endfunction

  logic [1:0]            state;
  rhe_cmd_t              cur;
  logic                  out_valid;
  logic                  load;
  logic                  acc_we;
  logic                  init_we;
  logic                  clr_we;
  logic                  ram_we;
  logic [BIN_BITS-1:0]   init_addr;
  logic [COUNT_BITS-1:0] pixels_seen;

  logic [BIN_BITS-1:0]   red_addr;
  logic [BIN_BITS-1:0]   green_addr;
  logic [BIN_BITS-1:0]   blue_addr;
  logic [BIN_BITS-1:0]   red_waddr;
  logic [BIN_BITS-1:0]   green_waddr;
  logic [BIN_BITS-1:0]   blue_waddr;
  logic [COUNT_BITS-1:0] red_wdata;
  logic [COUNT_BITS-1:0] green_wdata;
  logic [COUNT_BITS-1:0] blue_wdata;
  logic [COUNT_BITS-1:0] red_rdata;
  logic [COUNT_BITS-1:0] green_rdata;
  logic [COUNT_BITS-1:0] blue_rdata;
  logic [COUNT_BITS-1:0] counts [4];
  logic [OUT_BITS-1:0]   counts_out [4];

  assign cmd_pop    = (state == S_IDLE) && cmd_valid;
  assign red_addr   = cur.red_bin[BIN_BITS-1:0];
  assign green_addr = cur.green_bin[BIN_BITS-1:0];
  assign blue_addr  = cur.blue_bin[BIN_BITS-1:0];

  assign counts[0] = red_rdata;
  assign counts[1] = green_rdata;
  assign counts[2] = blue_rdata;
  assign counts[3] = pixels_seen;

  for (genvar i = 0; i < 4; i++) begin : g_out
    if (COUNT_BITS > OUT_BITS) begin : g_sat
      assign counts_out[i] = (|counts[i][COUNT_BITS-1:OUT_BITS]) ? OUT_MAX
                                                                   : counts[i][OUT_BITS-1:0];
    end else begin : g_ext
      assign counts_out[i] = OUT_BITS'(counts[i]);
    end
  end

  assign acc_we  = (state == S_EXEC) && !cur.is_read;
  assign load    = (state == S_EXEC) && cur.is_read && (!out_valid || pop);
  assign empty   = !out_valid;
  assign init_we = (state == S_INIT);
  // A clearing read writes zero back to the bin in all three memories.
  assign clr_we  = load && cur.in_range && clear_on_read;
  assign ram_we  = init_we || acc_we || clr_we;

  assign red_waddr   = init_we ? init_addr : red_addr;
  assign green_waddr = init_we ? init_addr : green_addr;
  assign blue_waddr  = init_we ? init_addr : blue_addr;
  assign red_wdata   = acc_we ? sat_inc(counts[0]) : '0;
  assign green_wdata = acc_we ? sat_inc(counts[1]) : '0;
  assign blue_wdata  = acc_we ? sat_inc(counts[2]) : '0;

  rhe_ram #(.WIDTH(COUNT_BITS), .DEPTH(BIN_COUNT)) u_red_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (red_waddr),
    .wdata (red_wdata),
    .re    (cmd_pop),
    .raddr (cmd.red_bin[BIN_BITS-1:0]),
    .rdata (red_rdata)
  );

  rhe_ram #(.WIDTH(COUNT_BITS), .DEPTH(BIN_COUNT)) u_green_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (green_waddr),
    .wdata (green_wdata),
    .re    (cmd_pop),
    .raddr (cmd.green_bin[BIN_BITS-1:0]),
    .rdata (green_rdata)
  );

  rhe_ram #(.WIDTH(COUNT_BITS), .DEPTH(BIN_COUNT)) u_blue_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (blue_waddr),
    .wdata (blue_wdata),
    .re    (cmd_pop),
    .raddr (cmd.blue_bin[BIN_BITS-1:0]),
    .rdata (blue_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cur <= cmd;
    end
    if (load) begin
      result.count_red   <= cur.in_range ? counts_out[0] : '0;
      result.count_green <= cur.in_range ? counts_out[1] : '0;
      result.count_blue  <= cur.in_range ? counts_out[2] : '0;
      result.pixel_total <= counts_out[3];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_INIT;
      init_addr   <= '0;
      out_valid   <= 1'b0;
      pixels_seen <= '0;
    end else begin
      unique case (state)
        S_INIT: begin
          init_addr <= init_addr + BIN_BITS'(1);
          if (init_addr == LAST_ADDR) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (cmd_pop) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (!cur.is_read || load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase

      if (load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end

      if (acc_we) begin
        pixels_seen <= sat_inc(pixels_seen);
      end
    end
  end

endmodule

>>> hdl/rgb_histogram_engine_core.sv
// Top level of the RGB histogram engine: register port, front end and update engine.
//
//   Channel   Direction  Handshake                 Payload
//   -------   ---------  ------------------------  ----------------------------------
//   items     in         push / full               item (mode, pixel, bin_index)
//   results   out        empty / pop               result (three bin counts, total)
//   config    in         psel/penable/pwrite/...   clear_on_read at byte address 0
//
// Each item passes through the update engine's IDLE state (bin read) and then its EXEC state
// (write-back); this read-modify-write loop takes no new item until the last is written back.
// A two-entry command queue lets items be taken while the engine is busy.
// Synchronous reset empties the queue and the result register; the engine then writes
// zero to every bin before it takes its first command.
// A read stalls the engine, and the items queued behind it, while an earlier result waits to be popped.
module rgb_histogram_engine_core #(
  parameter int BIN_COUNT  = 256,
  parameter int COUNT_BITS = 24
) (
  input  logic                 clk,
  input  logic                 rst,
  // Item queue side.
  input  logic                 push,
  input  rhe_pkg::rhe_item_t   item,
  output logic                 full,
  // Result queue side.
  output logic                 empty,
  input  logic                 pop,
  output rhe_pkg::rhe_result_t result,
  // Register port.
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import rhe_pkg::*;

  logic     clear_on_read;
  logic     reg_write;
  logic     cmd_valid;
  logic     cmd_pop;
  rhe_cmd_t cmd;

  // The register port never inserts wait states.
  assign pready    = 1'b1;
  assign reg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_on_read <= 1'b1;
    end else if (reg_write && (paddr[2] == REG_CLEAR_ON_READ)) begin
      clear_on_read <= pwdata[0];
    end
  end

  // Reads of addresses beyond the single register return zero.
  assign prdata = (paddr[2] == REG_CLEAR_ON_READ) ? {31'b0, clear_on_read} : '0;

  // The front end splits each pixel into its three bins and queues the command.
  rhe_front #(.BIN_COUNT(BIN_COUNT)) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .item      (item),
    .full      (full),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  // The update engine owns the bin memories, the pixel total and the result register.
  rhe_back #(.BIN_COUNT(BIN_COUNT), .COUNT_BITS(COUNT_BITS)) u_back (
    .clk           (clk),
    .rst           (rst),
    .clear_on_read (clear_on_read),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_pop       (cmd_pop),
    .empty         (empty),
    .pop           (pop),
    .result        (result)
  );

endmodule
